/* design/gated_nearest_track_associator_assert.svh */
// assertion macros for the track associator checker
`ifndef GATED_NEAREST_TRACK_ASSOCIATOR_ASSERT_SVH
`define GATED_NEAREST_TRACK_ASSOCIATOR_ASSERT_SVH

// clocked assertion with reset disable
`define GNTA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked same-cycle implication with reset disable
`define GNTA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* design/gnta_pkg.sv */
// shared types, constants and helpers of the track associator
package gnta_pkg;

    typedef enum logic [1:0] {
        KIND_DETECT = 2'd0,
        KIND_FRAME  = 2'd1,
        KIND_SEED   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CFG_PERSIST = 2'd0,
        CFG_BASE    = 2'd1,
        CFG_GROWTH  = 2'd2,
        CFG_NONE    = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_SCAN,
        ST_DRAIN,
        ST_NOMATCH,
        ST_UPD_RD,
        ST_UPD_MUL,
        ST_UPD_WR,
        ST_AGE_RD,
        ST_AGE_MUL,
        ST_AGE_WR
    } state_t;

    typedef struct packed {
        logic signed [19:0] row;
        logic signed [19:0] col;
        logic signed [19:0] vy;
        logic signed [19:0] vx;
        logic [15:0]        size;
        logic [7:0]         miss;
        logic [15:0]        hit;
    } track_t;

    typedef struct packed {
        logic cap;
        logic cnt_clr;
        logic cnt_inc;
        logic scan_rd;
        logic best_rd;
        logic age_rd;
        logic upd_mul;
        logic upd_wr;
        logic nomatch;
        logic age_mul;
        logic age_wr;
        logic seed_wr;
    } cmd_t;

    typedef struct packed {
        logic scan_busy;
        logic found;
        logic out_free;
        logic cnt_last;
        logic cnt_rep;
    } status_t;

    localparam logic [16:0] K_DECAY   = 17'd58982;
    localparam logic [16:0] K_GAIN    = 17'd19661;
    localparam logic [16:0] K_DAMP    = 17'd62915;
    localparam int          MAX_REPORTS = 32;

    function automatic logic signed [19:0] sat20(input logic signed [23:0] v);
        logic signed [19:0] r;
        if (v > 24'sd524287) begin
            r = 20'sd524287;
        end else if (v < -24'sd524288) begin
            r = -20'sd524288;
        end else begin
            r = v[19:0];
        end
        return r;
    endfunction

endpackage

/* design/gated_nearest_track_associator.sv */
// top level of the gated nearest-neighbor track associator
// Input beats (s_ channel) carry a kind: detection, frame end or seed.
// A seed writes one track entry and gives no result.
// A detection reads every track through one distance pipeline, one track
// per cycle, then updates the winner if one was found, and
// gives one result beat (matched or not) on the m_ channel.
// A frame end ages each track in turn (read, multiply, write), one report
// beat per track for the first 32 tracks, with m_last on the final one.
// The block takes one input beat at a time; s_ready is high while idle.
// Result beats sit in an output register; a stalled receiver holds the
// sequencer only where it has a new beat to place there.
// cfg_wr_en writes persistence limit, base radius or radius growth,
// indexed 0 to 2; the user must do so only while the block is idle, as the block does not enforce it.
// Synchronous reset returns the sequencer to idle, marks every track
// entry as zero through its valid bit and restores the register defaults.
module gated_nearest_track_associator
    import gnta_pkg::*;
#(
    parameter int NUM_TRACKS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic signed [19:0] s_pos_y,
    input  logic signed [19:0] s_pos_x,
    input  logic [15:0]        s_blob_size,
    input  logic [4:0]         s_seed_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_is_report,
    output logic               m_matched,
    output logic [4:0]         m_track_id,
    output logic signed [19:0] m_track_y,
    output logic signed [19:0] m_track_x,
    output logic signed [19:0] m_speed_y,
    output logic signed [19:0] m_speed_x,
    output logic [15:0]        m_track_size,
    output logic [7:0]         m_misses,
    output logic [15:0]        m_hits,
    output logic               m_last,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    cmd_t    cmd;
    status_t stat;

    gnta_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    gnta_dp #(
        .NUM_TRACKS (NUM_TRACKS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_pos_y      (s_pos_y),
        .s_pos_x      (s_pos_x),
        .s_blob_size  (s_blob_size),
        .s_seed_index (s_seed_index),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_is_report  (m_is_report),
        .m_matched    (m_matched),
        .m_track_id   (m_track_id),
        .m_track_y    (m_track_y),
        .m_track_x    (m_track_x),
        .m_speed_y    (m_speed_y),
        .m_speed_x    (m_speed_x),
        .m_track_size (m_track_size),
        .m_misses     (m_misses),
        .m_hits       (m_hits),
        .m_last       (m_last)
    );

endmodule

/* design/gnta_ctrl.sv */
// sequencing state machine of the track associator
module gnta_ctrl
    import gnta_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  logic [1:0] s_kind,
    output logic    s_ready,
    input  status_t stat,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.cap     = 1'b1;
                    cmd.cnt_clr = 1'b1;
                    unique case (kind_t'(s_kind))
                        KIND_DETECT: state_next = ST_SCAN;
                        KIND_FRAME:  state_next = ST_AGE_RD;
                        KIND_SEED:   state_next = ST_SEED;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SEED: begin
                cmd.seed_wr = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (stat.cnt_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!stat.scan_busy) begin
                    state_next = stat.found ? ST_UPD_RD : ST_NOMATCH;
                end
            end
            ST_NOMATCH: begin
                if (stat.out_free) begin
                    cmd.nomatch = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_UPD_RD: begin
                cmd.best_rd = 1'b1;
                state_next  = ST_UPD_MUL;
            end
            ST_UPD_MUL: begin
                cmd.upd_mul = 1'b1;
                state_next  = ST_UPD_WR;
            end
            ST_UPD_WR: begin
                if (stat.out_free) begin
                    cmd.upd_wr = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_AGE_RD: begin
                cmd.age_rd = 1'b1;
                state_next = ST_AGE_MUL;
            end
            ST_AGE_MUL: begin
                cmd.age_mul = 1'b1;
                state_next  = ST_AGE_WR;
            end
            ST_AGE_WR: begin
                if (stat.out_free || !stat.cnt_rep) begin
                    cmd.age_wr = 1'b1;
                    if (stat.cnt_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.cnt_inc = 1'b1;
                        state_next  = ST_AGE_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

/* design/gnta_dp.sv */
// track table, distance pipeline, update arithmetic and output register
module gnta_dp
    import gnta_pkg::*;
#(
    parameter int NUM_TRACKS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cmd_t               cmd,
    output status_t            stat,
    input  logic signed [19:0] s_pos_y,
    input  logic signed [19:0] s_pos_x,
    input  logic [15:0]        s_blob_size,
    input  logic [4:0]         s_seed_index,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_is_report,
    output logic               m_matched,
    output logic [4:0]         m_track_id,
    output logic signed [19:0] m_track_y,
    output logic signed [19:0] m_track_x,
    output logic signed [19:0] m_speed_y,
    output logic signed [19:0] m_speed_x,
    output logic [15:0]        m_track_size,
    output logic [7:0]         m_misses,
    output logic [15:0]        m_hits,
    output logic               m_last
);

    localparam int IW   = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
    localparam int NREP = (NUM_TRACKS < MAX_REPORTS) ? NUM_TRACKS : MAX_REPORTS;

    // configuration
    logic [7:0]  persist_reg;
    logic [15:0] base_reg, growth_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            persist_reg <= 8'd7;
            base_reg    <= 16'd320;
            growth_reg  <= 16'd112;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PERSIST: persist_reg <= cfg_data[7:0];
                CFG_BASE:    base_reg    <= cfg_data;
                CFG_GROWTH:  growth_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    // captured input beat
    logic signed [19:0] py_reg, px_reg;
    logic [15:0]        bsize_reg;
    logic [4:0]         sidx_reg;

    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            py_reg    <= s_pos_y;
            px_reg    <= s_pos_x;
            bsize_reg <= s_blob_size;
            sidx_reg  <= s_seed_index;
        end
    end

    // track counter
    logic [IW-1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.cnt_clr) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_inc) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // track memory with per-entry valid bits
    track_t                track_mem [NUM_TRACKS];
    logic [NUM_TRACKS-1:0] vld_reg;
    track_t                rd_data_reg;
    logic                  rd_vld_reg;
    track_t                entry;
    logic                  rd_en, wr_en;
    logic [IW-1:0]         rd_addr, wr_addr, best_idx_reg;
    track_t                wr_data;

    assign rd_en   = cmd.scan_rd | cmd.best_rd | cmd.age_rd;
    assign rd_addr = cmd.best_rd ? best_idx_reg : cnt_reg;
    assign entry   = rd_vld_reg ? rd_data_reg : '0;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            track_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= track_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // scan pipeline: difference and radius, squares, compare
    logic               p1_reg, p2_reg, p3_reg;
    logic [IW-1:0]      i1_reg, i2_reg, i3_reg;
    logic signed [20:0] dy_reg, dx_reg;
    logic [24:0]        rr_reg;
    logic               gate2_reg, gate3_reg;
    logic [40:0]        sqy_reg, sqx_reg;
    logic [41:0]        rsq_reg;
    logic               rbig_reg;
    logic signed [41:0] sqy_full, sqx_full;
    logic [41:0]        d_sum;
    logic               skip;
    logic               found_reg;
    logic [41:0]        best_reg;

    assign sqy_full = dy_reg * dy_reg;
    assign sqx_full = dx_reg * dx_reg;
    assign d_sum    = {1'b0, sqy_reg} + {1'b0, sqx_reg};
    assign skip     = gate3_reg && !rbig_reg && (d_sum > rsq_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_reg    <= 1'b0;
            p2_reg    <= 1'b0;
            p3_reg    <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            p1_reg <= cmd.scan_rd;
            p2_reg <= p1_reg;
            p3_reg <= p2_reg;
            if (cmd.cap) begin
                found_reg <= 1'b0;
            end else if (p3_reg && !skip && (!found_reg || d_sum < best_reg)) begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        i1_reg    <= cnt_reg;
        i2_reg    <= i1_reg;
        i3_reg    <= i2_reg;
        dy_reg    <= 21'(py_reg) - 21'(entry.row);
        dx_reg    <= 21'(px_reg) - 21'(entry.col);
        rr_reg    <= 25'(base_reg) + 25'(entry.miss) * 25'(growth_reg);
        gate2_reg <= entry.miss < persist_reg;
        sqy_reg   <= sqy_full[40:0];
        sqx_reg   <= sqx_full[40:0];
        rsq_reg   <= rr_reg[20:0] * rr_reg[20:0];
        rbig_reg  <= |rr_reg[24:21];
        gate3_reg <= gate2_reg;
        if (p3_reg && !skip && (!found_reg || d_sum < best_reg)) begin
            best_reg     <= d_sum;
            best_idx_reg <= i3_reg;
        end
    end

    // match update products
    logic signed [36:0] vy_dec_reg, vx_dec_reg;
    logic signed [37:0] gy_reg, gx_reg;
    logic               vupd_reg;
    logic signed [20:0] udy, udx;

    assign udy = 21'(py_reg) - 21'(entry.row);
    assign udx = 21'(px_reg) - 21'(entry.col);

    always_ff @(posedge aclk) begin
        if (cmd.upd_mul) begin
            vy_dec_reg <= 37'(entry.vy) * 37'($signed(K_DECAY));
            vx_dec_reg <= 37'(entry.vx) * 37'($signed(K_DECAY));
            gy_reg     <= 38'(udy) * 38'($signed(K_GAIN));
            gx_reg     <= 38'(udx) * 38'($signed(K_GAIN));
            vupd_reg   <= entry.miss <= 8'd1;
        end
    end

    track_t             upd_t;
    logic signed [20:0] vy_dq, vx_dq;
    logic signed [21:0] gy_q, gx_q;

    assign vy_dq = vy_dec_reg[36:16];
    assign vx_dq = vx_dec_reg[36:16];
    assign gy_q  = gy_reg[37:16];
    assign gx_q  = gx_reg[37:16];

    always_comb begin
        upd_t      = entry;
        if (vupd_reg) begin
            upd_t.vy = sat20(24'(vy_dq) + 24'(gy_q));
            upd_t.vx = sat20(24'(vx_dq) + 24'(gx_q));
        end
        upd_t.row  = py_reg;
        upd_t.col  = px_reg;
        upd_t.size = bsize_reg;
        upd_t.miss = {2'b00, entry.miss[7:2]};
        upd_t.hit  = (entry.hit == 16'hFFFF) ? entry.hit : entry.hit + 16'd1;
    end

    // frame-end aging
    logic [7:0]         am_reg;
    logic               aclr_reg;
    logic signed [19:0] arow_reg, acol_reg;
    logic signed [36:0] dy_damp_reg, dx_damp_reg;
    logic [7:0]         am;
    logic               aclr;
    logic signed [19:0] avy, avx;
    track_t             age_t;

    always_comb begin
        am   = (entry.miss == 8'hFF) ? entry.miss : entry.miss + 8'd1;
        aclr = am > persist_reg;
        avy  = aclr ? 20'sd0 : entry.vy;
        avx  = aclr ? 20'sd0 : entry.vx;
    end

    always_ff @(posedge aclk) begin
        if (cmd.age_mul) begin
            am_reg      <= am;
            aclr_reg    <= aclr;
            arow_reg    <= sat20(24'(entry.row) + 24'(avy));
            acol_reg    <= sat20(24'(entry.col) + 24'(avx));
            dy_damp_reg <= 37'(avy) * 37'($signed(K_DAMP));
            dx_damp_reg <= 37'(avx) * 37'($signed(K_DAMP));
        end
    end

    always_comb begin
        age_t      = entry;
        age_t.row  = arow_reg;
        age_t.col  = acol_reg;
        age_t.vy   = dy_damp_reg[35:16];
        age_t.vx   = dx_damp_reg[35:16];
        age_t.miss = am_reg;
        age_t.hit  = aclr_reg ? 16'd0 : entry.hit;
    end

    // write port selection
    logic   seed_ok;
    track_t seed_t;

    assign seed_ok = 32'(sidx_reg) < NUM_TRACKS;

    always_comb begin
        seed_t     = '0;
        seed_t.row = py_reg;
        seed_t.col = px_reg;
    end

    always_comb begin
        wr_en   = cmd.upd_wr | cmd.age_wr | (cmd.seed_wr & seed_ok);
        wr_addr = cnt_reg;
        wr_data = age_t;
        if (cmd.upd_wr) begin
            wr_addr = best_idx_reg;
            wr_data = upd_t;
        end else if (cmd.seed_wr) begin
            wr_addr = IW'(sidx_reg);
            wr_data = seed_t;
        end
    end

    // output register
    logic   m_valid_reg;
    logic   rep_reg, match_reg, last_reg;
    logic [4:0] id_reg;
    track_t out_reg;
    logic   cnt_rep, emit;

    assign cnt_rep = 32'(cnt_reg) < MAX_REPORTS;
    assign emit    = cmd.nomatch | cmd.upd_wr | (cmd.age_wr & cnt_rep);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            rep_reg   <= cmd.age_wr;
            match_reg <= cmd.upd_wr;
            last_reg  <= cmd.age_wr && (32'(cnt_reg) == NREP - 1);
            id_reg    <= cmd.upd_wr ? 5'(best_idx_reg) : (cmd.age_wr ? 5'(cnt_reg) : 5'd0);
            out_reg   <= cmd.upd_wr ? upd_t : (cmd.age_wr ? age_t : '0);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_is_report  = rep_reg;
    assign m_matched    = match_reg;
    assign m_track_id   = id_reg;
    assign m_track_y    = out_reg.row;
    assign m_track_x    = out_reg.col;
    assign m_speed_y    = out_reg.vy;
    assign m_speed_x    = out_reg.vx;
    assign m_track_size = out_reg.size;
    assign m_misses     = out_reg.miss;
    assign m_hits       = out_reg.hit;
    assign m_last       = last_reg;

    assign stat.scan_busy = p1_reg | p2_reg | p3_reg;
    assign stat.found     = found_reg;
    assign stat.out_free  = !m_valid_reg || m_ready;
    assign stat.cnt_last  = cnt_reg == IW'(NUM_TRACKS - 1);
    assign stat.cnt_rep   = cnt_rep;

endmodule

/* design/gnta_checker.sv */
// port-level checker of the track associator, bound to the top level
`include "gated_nearest_track_associator_assert.svh"

module gnta_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_is_report,
    input logic        m_matched,
    input logic [4:0]  m_track_id,
    input logic [15:0] m_hits,
    input logic        m_last
);

    `GNTA_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid, "result beat dropped while stalled")
    `GNTA_ASSERT_IMP(a_rep_unmatched, m_valid && m_is_report, !m_matched, "report beat flagged matched")
    `GNTA_ASSERT_IMP(a_ans_no_last, m_valid && !m_is_report, !m_last, "detection beat flagged last")
    `GNTA_ASSERT_IMP(a_miss_zero, m_valid && !m_is_report && !m_matched, m_track_id == 5'd0 && m_hits == 16'd0, "unmatched beat not zero")

endmodule

bind gated_nearest_track_associator gnta_checker u_gnta_checker (.*);
